// ----- design/absr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// absr_pkg: shared types and constants of the aligned block range splitter
// Holds the transaction payloads, status codes and controller command types.
// ----------------------------------------------------------------------------
package absr_pkg;

    // Result status codes.
    localparam logic [1:0] ST_PAGE       = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_MISALIGNED = 2'd2;
    localparam logic [1:0] ST_WRAP       = 2'd3;

    // Minimum page size register: reset value and legal range.
    localparam logic [4:0] MIN_LOG2_RESET = 5'd12;
    localparam logic [4:0] MIN_LOG2_LO    = 5'd4;
    localparam logic [4:0] MIN_LOG2_HI    = 5'd20;

    // Upper bound on the pages emitted for one range.
    localparam int MAX_RESULTS = 56;
    localparam int CNT_W       = 6;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
    } t_range_req;

    typedef struct packed {
        logic [31:0] page_address;
        logic [4:0]  page_size_log2;
        logic [1:0]  status;
        logic        last_page;
    } t_page_rsp;

    typedef struct packed {
        logic [4:0] min_page_log2;
    } t_cfg_wr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch a new range
        logic check_emit;  // write a status result
        logic load;        // start splitting the checked range
        logic step;        // emit one page
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_bad;   // empty, misaligned or wrapping range
        logic page_last;   // the current page ends the range or is the last page allowed
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- design/absr_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// absr_stream_if: valid/ready channel
// Carries one payload of a given type per transaction.
// ----------------------------------------------------------------------------
interface absr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/absr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// absr_dp: datapath of the aligned block range splitter
// Range checks, page cursor and remaining length, result register and the
// minimum page size register.
// ----------------------------------------------------------------------------
module absr_dp import absr_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    input  wire t_range_req i_req,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data,
    output t_page_rsp       o_rsp
);
    localparam int AW  = ADDR_WIDTH;
    localparam int XW  = (AW > 32) ? AW : 32;
    localparam int EW  = ((AW > 20) ? AW : 20) + 1;
    localparam int LGW = $clog2(AW);
    localparam int LW  = (LGW > 5) ? LGW : 5;

    // Index of the highest set bit.
    function automatic logic [LGW-1:0] f_hi_bit(input logic [AW-1:0] v);
        logic [LGW-1:0] r;
        r = '0;
        for (int i = 0; i < AW; i++) begin
            if (v[i]) r = LGW'(i);
        end
        return r;
    endfunction

    // Index of the lowest set bit.
    function automatic logic [LGW-1:0] f_lo_bit(input logic [AW-1:0] v);
        logic [LGW-1:0] r;
        r = '0;
        for (int i = AW - 1; i >= 0; i--) begin
            if (v[i]) r = LGW'(i);
        end
        return r;
    endfunction

    logic [4:0]       r_min_log2;
    logic [AW-1:0]    r_start;
    logic [AW-1:0]    r_end;
    logic [AW-1:0]    r_cursor;
    logic [AW-1:0]    r_rest;
    logic [CNT_W-1:0] r_count;
    t_page_rsp        r_rsp;

    logic [XW-1:0]  s_start_x;
    logic [XW-1:0]  s_end_x;
    logic [EW-1:0]  s_low_mask;
    logic [EW-1:0]  s_up;
    logic [EW-1:0]  s_rounded;
    logic           s_empty;
    logic           s_mis;
    logic           s_wrap;
    logic [1:0]     s_status;
    logic [LGW-1:0] s_hb;
    logic [LGW-1:0] s_tz;
    logic [LGW-1:0] s_lg;
    logic [LW-1:0]  s_lg_x;
    logic [AW-1:0]  s_size;
    logic [XW-1:0]  s_cursor_x;
    logic           s_page_last;
    logic [4:0]     n_min_log2;

    assign s_start_x = XW'(i_req.range_start);
    assign s_end_x   = XW'(i_req.range_end);

    // Range checks on the captured range.
    assign s_low_mask = (EW'(1) << r_min_log2) - EW'(1);
    assign s_empty    = (r_start >= r_end);
    assign s_mis      = ((EW'(r_start) & s_low_mask) != '0);
    assign s_up       = EW'(r_end) + s_low_mask;
    assign s_wrap     = (s_up[EW-1:AW] != '0);
    assign s_rounded  = s_up & ~s_low_mask;

    always_comb begin
        if (s_empty) begin
            s_status = ST_EMPTY;
        end else if (s_mis) begin
            s_status = ST_MISALIGNED;
        end else if (s_wrap) begin
            s_status = ST_WRAP;
        end else begin
            s_status = ST_PAGE;
        end
    end

    // Page size: limited by the remaining length and by the cursor's alignment.
    // A cursor at zero is aligned to any size.
    assign s_hb = f_hi_bit(r_rest);
    assign s_tz = f_lo_bit(r_cursor);
    assign s_lg = ((r_cursor != '0) && (s_tz < s_hb)) ? s_tz : s_hb;
    assign s_size = AW'(1) << s_lg;
    assign s_lg_x = LW'(s_lg);
    assign s_cursor_x = XW'(r_cursor);

    assign s_page_last = (r_rest == s_size) ||
                         (r_count == CNT_W'(MAX_RESULTS - 1));
    assign o_sts = '{range_bad: (s_status != ST_PAGE), page_last: s_page_last};

    always_comb begin
        if (i_cfg_data < MIN_LOG2_LO) begin
            n_min_log2 = MIN_LOG2_LO;
        end else if (i_cfg_data > MIN_LOG2_HI) begin
            n_min_log2 = MIN_LOG2_HI;
        end else begin
            n_min_log2 = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_log2 <= MIN_LOG2_RESET;
        end else if (i_cfg_we) begin
            r_min_log2 <= n_min_log2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= s_start_x[AW-1:0];
            r_end   <= s_end_x[AW-1:0];
        end
        if (i_cmd.load) begin
            r_cursor <= r_start;
            r_rest   <= s_rounded[AW-1:0] - r_start;
            r_count  <= '0;
        end else if (i_cmd.step) begin
            r_cursor <= r_cursor + s_size;
            r_rest   <= r_rest - s_size;
            r_count  <= r_count + CNT_W'(1);
        end
        if (i_cmd.check_emit) begin
            r_rsp.page_address   <= '0;
            r_rsp.page_size_log2 <= '0;
            r_rsp.status         <= s_status;
            r_rsp.last_page      <= 1'b1;
        end else if (i_cmd.step) begin
            r_rsp.page_address   <= s_cursor_x[31:0];
            r_rsp.page_size_log2 <= s_lg_x[4:0];
            r_rsp.status         <= ST_PAGE;
            r_rsp.last_page      <= s_page_last;
        end
    end

    assign o_rsp = r_rsp;

    a_step_has_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rest != '0))
        else $error("page step with nothing left of the range");

endmodule
`default_nettype wire

// ----- design/absr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// absr_ctrl: controller of the aligned block range splitter
// Sequences capture, check and page emission, and owns the result valid flag.
// ----------------------------------------------------------------------------
module absr_ctrl import absr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_SPLIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   s_slot_free;

    assign s_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (s_slot_free) begin
                    if (i_sts.range_bad) begin
                        o_cmd.check_emit = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (s_slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.page_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.check_emit || o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.page_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the last page");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.check_emit || o_cmd.step) |=> r_out_valid)
        else $error("result written without raising valid");

endmodule
`default_nettype wire

// ----- design/aligned_block_range_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aligned_block_range_splitter: cover a byte range with aligned power-of-two pages
// Rounds the end up to the minimum page size and streams the covering pages.
// ----------------------------------------------------------------------------
// Sequence: the range is captured in the idle state; the check state then writes
// a status result or loads the split, and the split state emits the pages.
// A split range gives at most 56 pages, one page per cycle while the result
// register is free (no result waits, or the receiver takes the waiting one).
// A new range is taken while the last result of the previous one still waits.
// Reset (synchronous, active low) idles the controller, clears the result valid
// flag and sets the minimum page size to 4 KiB; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aligned_block_range_splitter import absr_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    absr_stream_if.sink   i_range,
    absr_stream_if.source o_page,
    absr_stream_if.sink   i_cfg
);
    // The controller and the datapath talk only through these two structs.
    t_dp_cmd   s_cmd;
    t_dp_sts   s_sts;
    t_page_rsp s_rsp;
    t_cfg_wr   s_cfg;

    // The configuration register is always writable; writes must only be made
    // while the block is idle, and the block itself does not enforce that.
    assign i_cfg.ready = 1'b1;
    assign s_cfg       = i_cfg.payload;

    absr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_range.valid),
        .o_in_ready  (i_range.ready),
        .o_out_valid (o_page.valid),
        .i_out_ready (o_page.ready),
        .o_cmd       (s_cmd),
        .i_sts       (s_sts)
    );

    absr_dp #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .o_sts      (s_sts),
        .i_req      (i_range.payload),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (s_cfg.min_page_log2),
        .o_rsp      (s_rsp)
    );

    assign o_page.payload = s_rsp;

    // Every status result closes its range.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_page.valid && (o_page.payload.status != ST_PAGE))
            |-> o_page.payload.last_page)
        else $error("status result without the last flag");

    // Every emitted page is aligned to its own size.
    a_page_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_page.valid && (o_page.payload.status == ST_PAGE)) |->
            (((o_page.payload.page_address >> o_page.payload.page_size_log2)
              << o_page.payload.page_size_log2) == o_page.payload.page_address))
        else $error("page not aligned to its size");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the aligned block range splitter
// Sends byte ranges under several minimum page sizes and predicts the page
// cover of each one in a scoreboard. Every page or status transaction that
// comes back is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import absr_pkg::*;

    // Cycles with no transaction on any channel before the run is abandoned.
    // In a correct run the longest quiet stretch is a sender gap plus a
    // receiver stall plus the latency of the block.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles left after the last expected page, so late extra pages show up.
    localparam int END_SETTLE     = 16;
    // Mismatch lines printed before the rest are only counted.
    localparam int REPORT_CAP     = 20;

    // Kinds of random range.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_EMPTY,
        SHAPE_MISALIGNED,
        SHAPE_WRAP,
        SHAPE_SPLIT
    } t_range_shape;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the minimum page size register and
    // turns each accepted range into the pages (or the status result) that
    // the splitter must produce.
    // ------------------------------------------------------------------------
    class page_cover_scoreboard;
        t_page_rsp   expected_pages[$];
        logic [4:0]  min_page_log2;
        int          mismatches;
        int          pages_seen;
        int          status_seen;
        int          ranges_seen;

        function new();
            min_page_log2 = MIN_LOG2_RESET;
            mismatches    = 0;
            pages_seen    = 0;
            status_seen   = 0;
            ranges_seen   = 0;
        endfunction

        // Out of range writes saturate to the legal bounds.
        function void write_min_page(logic [4:0] value);
            if (value < MIN_LOG2_LO)
                min_page_log2 = MIN_LOG2_LO;
            else if (value > MIN_LOG2_HI)
                min_page_log2 = MIN_LOG2_HI;
            else
                min_page_log2 = value;
        endfunction

        function void push_status(logic [1:0] code);
            expected_pages.push_back('{page_address: 32'd0, page_size_log2: 5'd0,
                                       status: code, last_page: 1'b1});
        endfunction

        // Works in 64 bits so that the rounding overflow is visible.
        function void note_range(t_range_req req);
            logic [63:0] first_addr;
            logic [63:0] stop_addr;
            logic [63:0] page_bytes;
            logic [63:0] rounded_up;
            logic [63:0] cover_end;
            logic [63:0] cursor;
            logic [63:0] remaining;
            logic [63:0] base;
            int          size_log2;
            int          align_log2;
            int          count;
            logic        is_last;

            ranges_seen++;
            first_addr = {32'd0, req.range_start};
            stop_addr  = {32'd0, req.range_end};
            page_bytes = 64'd1 << min_page_log2;
            rounded_up = stop_addr + page_bytes - 64'd1;

            // The empty test wins over alignment, and alignment over the wrap.
            if (first_addr >= stop_addr) begin
                push_status(ST_EMPTY);
            end else if ((first_addr & (page_bytes - 64'd1)) != 64'd0) begin
                push_status(ST_MISALIGNED);
            end else if (rounded_up > 64'hFFFF_FFFF) begin
                push_status(ST_WRAP);
            end else begin
                cover_end = rounded_up & ~(page_bytes - 64'd1);
                cursor    = first_addr;
                count     = 0;
                while (count < MAX_RESULTS) begin
                    remaining = cover_end - cursor;
                    base      = cursor;
                    size_log2 = 0;
                    for (int b = 1; b < 64; b++)
                        if (remaining[b])
                            size_log2 = b;
                    // Address zero is aligned to any size.
                    if (base != 64'd0) begin
                        align_log2 = 0;
                        while (!base[align_log2])
                            align_log2++;
                        if (align_log2 < size_log2)
                            size_log2 = align_log2;
                    end
                    cursor  = base + (64'd1 << size_log2);
                    is_last = (cursor >= cover_end) || (count + 1 >= MAX_RESULTS);
                    expected_pages.push_back('{page_address: base[31:0],
                                               page_size_log2: size_log2[4:0],
                                               status: ST_PAGE,
                                               last_page: is_last});
                    count++;
                    if (is_last)
                        break;
                end
            end
        endfunction

        function void check_page(t_page_rsp got);
            t_page_rsp want;

            if (expected_pages.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected result addr=%h log2=%0d status=%0d last=%0d",
                             $time, got.page_address, got.page_size_log2, got.status,
                             got.last_page);
                return;
            end
            want = expected_pages.pop_front();
            if (want.status == ST_PAGE)
                pages_seen++;
            else
                status_seen++;
            if (got.page_address !== want.page_address ||
                got.page_size_log2 !== want.page_size_log2 ||
                got.status !== want.status ||
                got.last_page !== want.last_page) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: mismatch expected %h/%0d/%0d/%0d actual %h/%0d/%0d/%0d",
                             $time, want.page_address, want.page_size_log2, want.status,
                             want.last_page, got.page_address, got.page_size_log2,
                             got.status, got.last_page);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    absr_stream_if #(.T(t_range_req)) range_if ();
    absr_stream_if #(.T(t_page_rsp))  page_if ();
    absr_stream_if #(.T(t_cfg_wr))    cfg_if ();

    aligned_block_range_splitter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_range (range_if),
        .o_page  (page_if),
        .i_cfg   (cfg_if)
    );

    page_cover_scoreboard sb;

    // Idling switches for the sender and the receiver; the last phase turns
    // both off so the block also runs at full rate.
    bit sender_idle;
    bit receiver_idle;
    int configs_written;
    int quiet_cycles;
    bit progress;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: the page ready line drops in random bursts.
    // Bursts start only now and then, so long runs at full ready appear too.
    // ------------------------------------------------------------------------
    initial begin : receiver_stalls
        int stall_left;

        stall_left    = 0;
        page_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!receiver_idle)
                stall_left = 0;
            else if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 18);
            page_if.ready <= (stall_left == 0) && i_rst_n;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog. All three channels are sampled at the rising
    // edge. A page transaction is checked before a range transaction of the
    // same edge is noted, since that page can only belong to an older range.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (page_if.valid && page_if.ready) begin
                sb.check_page(page_if.payload);
                progress = 1'b1;
            end
            if (range_if.valid && range_if.ready) begin
                sb.note_range(range_if.payload);
                progress = 1'b1;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.write_min_page(cfg_if.payload.min_page_log2);
                configs_written++;
                progress = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, sb.expected_pages.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Drives one range and holds it until the transaction completes. After
    // it, the sender sometimes goes quiet for a random burst.
    task automatic send_range(input t_range_req req);
        int gap;

        @(negedge i_clk);
        range_if.valid   <= 1'b1;
        range_if.payload <= req;
        @(posedge i_clk);
        while (!range_if.ready)
            @(posedge i_clk);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            range_if.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge i_clk);
        end
    endtask

    // Stops the sender and waits until every predicted result has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        range_if.valid <= 1'b0;
        while (sb.expected_pages.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; only called once the block has drained.
    task automatic write_min_page(input logic [4:0] value);
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{min_page_log2: value};
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random phase. Most ranges are well formed so that the splitter really
    // walks through growing and shrinking pages; the rest are empty,
    // misaligned, wrapping or fully random ranges.
    // ------------------------------------------------------------------------
    task automatic run_phase(input int items, input bit pause_midway);
        t_range_shape shape;
        logic [63:0]  page_bytes;
        logic [63:0]  top_end;
        logic [63:0]  first_addr;
        logic [63:0]  stop_addr;
        int           pick;

        for (int n = 0; n < items; n++) begin
            // Pressure point: let the block empty out completely mid-phase.
            if (pause_midway && n == items / 2)
                wait_drained();
            page_bytes = 64'd1 << sb.min_page_log2;
            top_end    = 64'h1_0000_0000 - page_bytes;   // largest end that does not wrap
            pick       = $urandom_range(0, 19);
            shape      = pick < 2  ? SHAPE_NOISE      :
                         pick < 3  ? SHAPE_EMPTY      :
                         pick < 4  ? SHAPE_MISALIGNED :
                         pick < 5  ? SHAPE_WRAP       : SHAPE_SPLIT;
            case (shape)
                SHAPE_NOISE: begin
                    first_addr = {32'd0, $urandom};
                    stop_addr  = {32'd0, $urandom};
                end
                SHAPE_EMPTY: begin
                    first_addr = {32'd0, $urandom};
                    stop_addr  = {32'd0, $urandom_range(first_addr[31:0], 0)};
                end
                SHAPE_MISALIGNED: begin
                    first_addr = ({32'd0, $urandom} & ~(page_bytes - 64'd1)) |
                                 $urandom_range(page_bytes[31:0] - 1, 1);
                    stop_addr  = {32'd0, $urandom_range(32'hFFFF_FFFF,
                                                        first_addr[31:0] + 32'd1)};
                end
                SHAPE_WRAP: begin
                    stop_addr  = {32'd0, $urandom_range(32'hFFFF_FFFF, top_end[31:0] + 1)};
                    first_addr = {32'd0, $urandom_range(stop_addr[31:0] - 1, 0)} &
                                 ~(page_bytes - 64'd1);
                end
                default: begin
                    first_addr = {32'd0, $urandom} & ~(page_bytes - 64'd1);
                    if (first_addr >= top_end)
                        first_addr = 64'd0;
                    if ($urandom_range(0, 3) != 0)
                        stop_addr = first_addr +
                                    $urandom_range(page_bytes[31:0] << $urandom_range(0, 6), 1);
                    else
                        stop_addr = {32'd0, $urandom_range(top_end[31:0],
                                                           first_addr[31:0] + 1)};
                    if (stop_addr > top_end)
                        stop_addr = top_end;
                end
            endcase
            send_range('{first_addr[31:0], stop_addr[31:0]});
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a directed part at the reset page size and at
    // both saturated extremes, then random phases under several settings.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        logic [4:0] phase_setting [7];

        sb               = new();
        configs_written  = 0;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        i_rst_n          = 1'b0;
        range_if.valid   = 1'b0;
        range_if.payload = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.payload   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset page size of 4 KiB: status cases and their precedence.
        send_range('{32'h0000_0000, 32'h0000_0000});   // empty at zero
        send_range('{32'h0000_1000, 32'h0000_1000});   // empty, equal ends
        send_range('{32'hFFFF_FFFF, 32'h0000_0000});   // empty, start at the top
        send_range('{32'h0000_1001, 32'h0000_1000});   // empty beats misaligned
        send_range('{32'h0000_1001, 32'h0000_2000});   // misaligned
        send_range('{32'h0000_2001, 32'hFFFF_FFFF});   // misaligned beats wrap
        send_range('{32'h0000_0000, 32'hFFFF_FFFF});   // rounded end wraps
        send_range('{32'h0000_0000, 32'hFFFF_F001});   // wraps by one byte
        send_range('{32'hFFFF_F000, 32'hFFFF_FFFF});   // top page, but the end wraps
        // Page covers.
        send_range('{32'h0000_0000, 32'h0000_0001});   // one byte rounds to one page
        send_range('{32'h0000_0000, 32'h8000_0000});   // single 2 GiB page from zero
        send_range('{32'h0000_0000, 32'hFFFF_F000});   // shrinking pages from zero
        send_range('{32'h0000_1000, 32'hFFFF_F000});   // grow then shrink, whole space
        send_range('{32'hFFFF_E000, 32'hFFFF_F000});   // highest usable page
        send_range('{32'h0000_3000, 32'h0000_3001});
        send_range('{32'h0000_3000, 32'h0001_0000});

        // Written below the legal range: the block must use 16 byte pages.
        wait_drained();
        write_min_page(5'd0);
        send_range('{32'h0000_0008, 32'h0000_0100});   // misaligned at 16 bytes
        send_range('{32'h0000_0010, 32'h0000_0011});
        send_range('{32'h0000_0010, 32'hFFFF_FFF0});   // longest cover of the run

        // Written above the legal range: the block must use 1 MiB pages.
        wait_drained();
        write_min_page(5'd31);
        send_range('{32'h0008_0000, 32'h0020_0000});   // misaligned at 1 MiB
        send_range('{32'h0010_0000, 32'hFFF0_0001});   // rounding wraps
        send_range('{32'h0010_0000, 32'hFFF0_0000});
        send_range('{32'h0000_0000, 32'h0000_0001});

        // Random phases: both legal extremes, the reset value, both saturating
        // writes again, one random legal value, and a final full rate phase.
        phase_setting = '{5'd4, 5'd20, MIN_LOG2_RESET, 5'd3, 5'd21,
                          5'($urandom_range(MIN_LOG2_LO, MIN_LOG2_HI)), MIN_LOG2_RESET};
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            write_min_page(phase_setting[p]);
            if (p == 6) begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            run_phase(12, p == 0);
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Sent %0d ranges across %0d page size writes, saturating writes included.",
                 sb.ranges_seen, configs_written);
        $display("Checked %0d pages and %0d status results.", sb.pages_seen, sb.status_seen);
        if (sb.mismatches == 0 && sb.expected_pages.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
